@@ hdl/apw_pkg.sv @@
// Package for the PDU block walker: item types, status codes and register indexes.
// No dependencies; the other files of the block, but for apw_stream_if, refer to it by scoped names.

package apw_pkg;

  localparam int unsigned OffsetWidth = 20;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned MinLenWidth = 10;

  typedef logic [OffsetWidth-1:0] offset_t;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhFlags = 2'd1,
    PhLen1  = 2'd2,
    PhLen2  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    StatusOk         = 3'd0,
    StatusNoRoom     = 3'd1,
    StatusNoInherit  = 3'd2,
    StatusTooShort   = 3'd3,
    StatusPastEnd    = 3'd4
  } status_e;

  localparam logic [CfgIdxWidth-1:0] CfgVectorBytes = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgHeaderBytes = 1'b1;

  // Bit positions within the upper nibble of the flags byte.
  localparam int unsigned FlagL = 3;
  localparam int unsigned FlagV = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagD = 0;

  localparam logic [1:0] LenBytesShort = 2'd2;
  localparam logic [1:0] LenBytesLong  = 2'd3;

  typedef struct packed {
    logic [ByteWidth-1:0] data_byte;
    logic                 block_start;
    offset_t              block_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    offset_t    pdu_offset;
    offset_t    vector_offset;
    offset_t    header_offset;
    offset_t    data_offset;
    offset_t    data_length;
    offset_t    next_offset;
    logic       vector_inherited;
    logic       header_inherited;
    logic       data_inherited;
  } res_item_t;

endpackage

@@ hdl/apw_stream_if.sv @@
// Valid/ready stream channel carrying one payload item per transfer.
// Depends on nothing; the payload type is given by the instantiating code.

interface apw_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/apw_walk_core.sv @@
// Walker state and the per-byte decode of flags and length fields.
// Depends on apw_pkg; the result it forms is registered by apw_out_queue.

module apw_walk_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  apw_pkg::in_item_t              item_i,
  input  logic [apw_pkg::ByteWidth-1:0]  vector_bytes_i,
  input  logic [apw_pkg::ByteWidth-1:0]  header_bytes_i,
  output logic                           res_valid_o,
  output apw_pkg::res_item_t             res_o
);

  localparam int unsigned W = apw_pkg::OffsetWidth;

  apw_pkg::offset_t byte_position_q, byte_position_d;
  apw_pkg::offset_t block_end_q, block_end_d;
  apw_pkg::offset_t pdu_start_q, pdu_start_d;
  apw_pkg::phase_e  phase_q, phase_d;
  logic [3:0]       flag_bits_q, flag_bits_d;
  apw_pkg::offset_t length_accum_q, length_accum_d;
  logic [2:0]       have_prev_q, have_prev_d;
  apw_pkg::offset_t kept_v_q, kept_v_d;
  apw_pkg::offset_t kept_h_q, kept_h_d;
  apw_pkg::offset_t kept_d_q, kept_d_d;
  apw_pkg::offset_t kept_len_q, kept_len_d;

  // Effective state once a block start on this byte has been applied.
  apw_pkg::offset_t be, pos, ps;
  logic [2:0]       hp;
  apw_pkg::phase_e  ph;

  // Flags byte checks.
  logic [1:0]       new_len_bytes;
  logic             no_room;

  // Completion of a length field.
  logic                               own_v, own_h, own_d;
  logic [1:0]                         len_bytes;
  apw_pkg::offset_t                   acc;
  logic [apw_pkg::MinLenWidth-1:0]    min_len;
  logic                               inh_err, short_err, past_err;
  logic [W:0]                         pdu_end;
  apw_pkg::offset_t                   cur_v, cur_h, cur_d, dlen, cur_end;

  always_comb begin
    be  = item_i.block_start ? item_i.block_length : block_end_q;
    pos = item_i.block_start ? '0 : byte_position_q;
    ps  = item_i.block_start ? '0 : pdu_start_q;
    hp  = item_i.block_start ? 3'b000 : have_prev_q;
    if (item_i.block_start) begin
      ph = (item_i.block_length == '0) ? apw_pkg::PhIdle : apw_pkg::PhFlags;
    end else begin
      ph = phase_q;
    end
  end

  always_comb begin
    new_len_bytes = item_i.data_byte[apw_pkg::FlagL + 4] ? apw_pkg::LenBytesLong
                                                          : apw_pkg::LenBytesShort;
    no_room = ({1'b0, ps} + {{(W-1){1'b0}}, new_len_bytes}) >= {1'b0, be};
  end

  always_comb begin
    own_v     = flag_bits_q[apw_pkg::FlagV];
    own_h     = flag_bits_q[apw_pkg::FlagH];
    own_d     = flag_bits_q[apw_pkg::FlagD];
    len_bytes = flag_bits_q[apw_pkg::FlagL] ? apw_pkg::LenBytesLong : apw_pkg::LenBytesShort;
    acc       = {length_accum_q[W-apw_pkg::ByteWidth-1:0], item_i.data_byte};
    min_len   = {{(apw_pkg::MinLenWidth-2){1'b0}}, len_bytes}
              + (own_v ? {2'b00, vector_bytes_i} : '0)
              + (own_h ? {2'b00, header_bytes_i} : '0);
    inh_err   = (!own_v && !hp[0]) || (!own_h && !hp[1]) || (!own_d && !hp[2]);
    short_err = acc < {{(W-apw_pkg::MinLenWidth){1'b0}}, min_len};
    pdu_end   = {1'b0, ps} + {1'b0, acc};
    past_err  = pdu_end > {1'b0, be};
    cur_v     = ps + {{(W-2){1'b0}}, len_bytes};
    cur_h     = own_v ? cur_v + {{(W-apw_pkg::ByteWidth){1'b0}}, vector_bytes_i} : cur_v;
    cur_d     = own_h ? cur_h + {{(W-apw_pkg::ByteWidth){1'b0}}, header_bytes_i} : cur_h;
    dlen      = acc - (cur_d - ps);
    // With own data the PDU spans its whole length; otherwise it ends where its data would start.
    cur_end   = own_d ? pdu_end[W-1:0] : cur_d;
  end

  always_comb begin
    byte_position_d = byte_position_q;
    block_end_d     = block_end_q;
    pdu_start_d     = pdu_start_q;
    phase_d         = phase_q;
    flag_bits_d     = flag_bits_q;
    length_accum_d  = length_accum_q;
    have_prev_d     = have_prev_q;
    kept_v_d        = kept_v_q;
    kept_h_d        = kept_h_q;
    kept_d_d        = kept_d_q;
    kept_len_d      = kept_len_q;
    res_valid_o     = 1'b0;
    res_o           = '0;

    if (accept_i) begin
      block_end_d     = be;
      pdu_start_d     = ps;
      have_prev_d     = hp;
      phase_d         = ph;
      byte_position_d = pos;
      if (ph != apw_pkg::PhIdle) begin
        byte_position_d = pos + {{(W-1){1'b0}}, 1'b1};
        case (ph)
          apw_pkg::PhFlags: begin
            if (pos == ps) begin
              flag_bits_d    = item_i.data_byte[7:4];
              length_accum_d = {{(W-4){1'b0}}, item_i.data_byte[3:0]};
              if (no_room) begin
                res_valid_o       = 1'b1;
                res_o.status      = apw_pkg::StatusNoRoom;
                res_o.pdu_offset  = ps;
                phase_d           = apw_pkg::PhIdle;
              end else begin
                phase_d = apw_pkg::PhLen1;
              end
            end
          end
          apw_pkg::PhLen1, apw_pkg::PhLen2: begin
            length_accum_d = acc;
            if (ph == apw_pkg::PhLen1 && flag_bits_q[apw_pkg::FlagL]) begin
              phase_d = apw_pkg::PhLen2;
            end else begin
              res_valid_o      = 1'b1;
              res_o.pdu_offset = ps;
              if (inh_err || short_err || past_err) begin
                phase_d = apw_pkg::PhIdle;
                if (inh_err) begin
                  res_o.status = apw_pkg::StatusNoInherit;
                end else if (short_err) begin
                  res_o.status = apw_pkg::StatusTooShort;
                end else begin
                  res_o.status = apw_pkg::StatusPastEnd;
                end
              end else begin
                if (own_v) begin
                  kept_v_d = cur_v;
                end
                if (own_h) begin
                  kept_h_d = cur_h;
                end
                if (own_d) begin
                  kept_d_d   = cur_d;
                  kept_len_d = dlen;
                end
                have_prev_d            = 3'b111;
                res_o.status           = apw_pkg::StatusOk;
                res_o.vector_offset    = own_v ? cur_v : kept_v_q;
                res_o.header_offset    = own_h ? cur_h : kept_h_q;
                res_o.data_offset      = own_d ? cur_d : kept_d_q;
                res_o.data_length      = own_d ? dlen : kept_len_q;
                res_o.next_offset      = cur_end;
                res_o.vector_inherited = !own_v;
                res_o.header_inherited = !own_h;
                res_o.data_inherited   = !own_d;
                pdu_start_d            = cur_end;
                phase_d = (cur_end >= be) ? apw_pkg::PhIdle : apw_pkg::PhFlags;
              end
            end
          end
          default: begin
            phase_d = apw_pkg::PhIdle;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_position_q <= '0;
      block_end_q     <= '0;
      pdu_start_q     <= '0;
      phase_q         <= apw_pkg::PhIdle;
      flag_bits_q     <= '0;
      length_accum_q  <= '0;
      have_prev_q     <= '0;
      kept_v_q        <= '0;
      kept_h_q        <= '0;
      kept_d_q        <= '0;
      kept_len_q      <= '0;
    end else begin
      byte_position_q <= byte_position_d;
      block_end_q     <= block_end_d;
      pdu_start_q     <= pdu_start_d;
      phase_q         <= phase_d;
      flag_bits_q     <= flag_bits_d;
      length_accum_q  <= length_accum_d;
      have_prev_q     <= have_prev_d;
      kept_v_q        <= kept_v_d;
      kept_h_q        <= kept_h_d;
      kept_d_q        <= kept_d_d;
      kept_len_q      <= kept_len_d;
    end
  end

endmodule

@@ hdl/apw_out_queue.sv @@
// Two-entry result register that parts the walker from the output channel.
// Depends on apw_pkg for the result item type.

module apw_out_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  input  apw_pkg::res_item_t wr_data_i,
  output logic               has_room_o,
  output logic               rd_valid_o,
  input  logic               rd_ready_i,
  output apw_pkg::res_item_t rd_data_o
);

  apw_pkg::res_item_t entry_q [2];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         count_q, count_d;
  logic               do_rd;

  // Room for one more result is enough, since an input byte yields at most one.
  assign has_room_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = entry_q[rd_ptr_q];
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_valid_i;
    rd_ptr_d = rd_ptr_q ^ do_rd;
    count_d  = count_q + {1'b0, wr_valid_i} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ hdl/acn_pdu_block_walker.sv @@
// Top level of the PDU block walker: configuration registers, walker core, result queue.
// Depends on apw_pkg, apw_stream_if, apw_walk_core and apw_out_queue.
//
//   Channel  Direction  Payload            Transfer when
//   in_i     sink       apw_pkg::in_item_t  in_i.valid && in_i.ready
//   out_o    source     apw_pkg::res_item_t out_o.valid && out_o.ready
//   cfg      write      8-bit register      cfg_we_i
//
// One byte is taken per cycle while the queue has room; a result, if any, is queued with it.
// The walker state is updated in the cycle of the transfer, so the next byte follows at once.
// in_i.ready drops only while both entries of the result queue are full.
// Reset is asynchronous and returns the walker to idle with nothing to inherit.

module acn_pdu_block_walker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [apw_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [apw_pkg::ByteWidth-1:0]     cfg_data_i,
  apw_stream_if.sink                        in_i,
  apw_stream_if.source                      out_o
);

  logic [apw_pkg::ByteWidth-1:0] vector_bytes_q;
  logic [apw_pkg::ByteWidth-1:0] header_bytes_q;
  logic                          has_room;
  logic                          accept;
  logic                          res_valid;
  apw_pkg::res_item_t            res;

  assign in_i.ready = has_room;
  assign accept     = in_i.valid && has_room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vector_bytes_q <= 8'd4;
      header_bytes_q <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        apw_pkg::CfgVectorBytes: vector_bytes_q <= cfg_data_i;
        apw_pkg::CfgHeaderBytes: header_bytes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  apw_walk_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .item_i        (in_i.data),
    .vector_bytes_i(vector_bytes_q),
    .header_bytes_i(header_bytes_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  apw_out_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(res_valid),
    .wr_data_i (res),
    .has_room_o(has_room),
    .rd_valid_o(out_o.valid),
    .rd_ready_i(out_o.ready),
    .rd_data_o (out_o.data)
  );

endmodule

@@ hdl/apw_checker.sv @@
// Port-level checks for the PDU block walker, attached to the top level by bind.
// Depends on apw_pkg for the result item type and status codes.

module apw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input apw_pkg::res_item_t out_data_i
);

  // A result waiting for its transfer is neither dropped nor altered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result withdrawn or changed while stalled");

  // A fresh result follows a byte transfer in the previous cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result appeared without an input transfer");

  // An error result carries only its code and the PDU offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status != apw_pkg::StatusOk |->
      out_data_i.vector_offset == '0 && out_data_i.header_offset == '0 &&
      out_data_i.data_offset == '0 && out_data_i.data_length == '0 &&
      out_data_i.next_offset == '0 && !out_data_i.vector_inherited &&
      !out_data_i.header_inherited && !out_data_i.data_inherited)
    else $error("error result carries layout fields");

  // A good PDU always moves the walk forward past at least its length field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == apw_pkg::StatusOk |->
      {1'b0, out_data_i.next_offset} >= {1'b0, out_data_i.pdu_offset} + 21'd2)
    else $error("next PDU offset does not advance");

endmodule

bind acn_pdu_block_walker apw_checker u_apw_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);
